@@ rtl/pelf_pkg.sv @@
// Package for the pairwise edge length filter.
// Word types, field widths and register codes; no dependencies.
package pelf_pkg;

   localparam int COORD_W = 24;
   localparam int LEN_W   = 25;
   localparam int HUE_W   = 16;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int SQ_W    = 52;
   localparam int CSR_AW  = 4;

   localparam logic [1:0] CSR_MIN_LENGTH = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_HUE_OFFSET = 2'd2;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic                      first;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_word_type;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] older_index;
      logic [IDX_W-1:0] newer_index;
      logic [LEN_W-1:0] edge_length;
      logic [HUE_W-1:0] hue;
      logic [LEN_W-1:0] shortest;
      logic [LEN_W-1:0] longest;
      logic [CNT_W-1:0] point_count;
      logic             overflow;
      logic             last;
   } rsp_word_type;

endpackage

@@ rtl/pelf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pelf_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

@@ rtl/pelf_sqrt.sv @@
// Iterative rounded square root, one radicand bit pair per cycle.
// Uses pelf_pkg.
module pelf_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pelf_pkg::SQ_W-1:0] radicand,
   output logic                      done,
   output logic [pelf_pkg::LEN_W-1:0] root
);
   import pelf_pkg::*;

   localparam int W = SQ_W + 1;

   logic [W-1:0] n_ff, r_ff, bit_ff;
   logic         run_ff;
   logic [W-1:0] trial;

   assign trial = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            n_ff   <= W'(radicand);
            r_ff   <= '0;
            bit_ff <= W'(1) << (W - 1);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (bit_ff == '0) begin
               run_ff <= 1'b0;
               done   <= 1'b1;
               root   <= (n_ff > r_ff) ? LEN_W'(r_ff + W'(1)) : LEN_W'(r_ff);
            end else begin
               if (n_ff >= trial) begin
                  n_ff <= n_ff - trial;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
      end
   end
endmodule

@@ rtl/pelf_div.sv @@
// Restoring divider for the hue fraction: floor(a * 2^16 / d) mod 2^16, a <= d.
// One quotient bit per cycle. Uses pelf_pkg.
module pelf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pelf_pkg::LEN_W-1:0] dividend,
   input  logic [pelf_pkg::LEN_W-1:0] divisor,
   output logic                       done,
   output logic [pelf_pkg::HUE_W-1:0] quotient
);
   import pelf_pkg::*;

   logic [LEN_W:0]   rem_ff;
   logic [LEN_W-1:0] div_ff;
   logic [4:0]       cnt_ff;
   logic             run_ff;
   logic [LEN_W:0]   t;
   logic             ge;

   assign t  = (cnt_ff == 5'd0) ? rem_ff : {rem_ff[LEN_W-1:0], 1'b0};
   assign ge = t >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            rem_ff   <= {1'b0, dividend};
            div_ff   <= divisor;
            cnt_ff   <= '0;
            run_ff   <= 1'b1;
            quotient <= '0;
         end else if (run_ff) begin
            rem_ff   <= ge ? t - {1'b0, div_ff} : t;
            quotient <= {quotient[HUE_W-2:0], ge};
            cnt_ff   <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(HUE_W)) begin
               run_ff <= 1'b0;
               done   <= 1'b1;
            end
         end
      end
   end
endmodule

@@ rtl/pairwise_edge_length_filter.sv @@
// Top level of the pairwise edge length filter.
// Uses pelf_pkg, pelf_ram, pelf_sqrt and pelf_div.
//
//  channel   handshake                     payload
//  request   start / busy                  req_word
//  result    rsp_valid (one-cycle strobe)  rsp_word
//  config    psel penable pwrite pready     paddr pwdata prdata
//
// Each stored pair is handled in turn: RAM read, squares, sum, waiting on the
// square root, then the check. An accepted edge with max above min also waits
// for the divider. An item keeps busy high through each stored point plus the
// summary. Synchronous reset clears the count, the extremes and the length and
// hue registers; point RAM is not cleared. Results cannot be stalled.
module pairwise_edge_length_filter #(
   parameter int MAX_POINTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  pelf_pkg::req_word_type       req_word,
   output logic                         rsp_valid,
   output pelf_pkg::rsp_word_type       rsp_word,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pelf_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import pelf_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int RW = 3 * COORD_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_SQUARE, S_SUM, S_ROOT, S_CHECK, S_DIVIDE, S_STORE
   } state_type;

   state_type        state_ff;
   logic [LEN_W-1:0] min_len_ff, max_len_ff;
   logic [HUE_W-1:0] hue_off_ff;
   logic [CNT_W-1:0] count_ff;
   logic [LEN_W-1:0] run_min_ff, run_max_ff;
   logic [RW-1:0]    point_ff;
   logic [AW-1:0]    idx_ff, newer_ff;
   logic             dropped_ff;
   logic [2*LEN_W-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [LEN_W-1:0] len_ff;

   logic [SQ_W-1:0]  sum_sq;
   logic [RW-1:0]    rd_data;
   logic             sqrt_start, sqrt_done, div_start, div_done;
   logic [LEN_W-1:0] root;
   logic [HUE_W-1:0] quot;
   logic             cfg_wr, accepted, last_pair;
   logic [CNT_W-1:0] start_count, next_count;
   logic [LEN_W:0]   dx, dy, dz;
   logic [LEN_W-1:0] ax, ay, az;
   rsp_word_type     pair_word, summary_word;

   pelf_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_STORE && !dropped_ff),
      .wr_addr (newer_ff),
      .wr_data (point_ff),
      .rd_en   (state_ff == S_READ),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   pelf_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sqrt_start),
      .radicand (sum_sq), .done (sqrt_done), .root (root)
   );

   pelf_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (len_ff - min_len_ff), .divisor (max_len_ff - min_len_ff),
      .done (div_done), .quotient (quot)
   );

   assign pready     = 1'b1;
   assign busy       = state_ff != S_IDLE;
   assign cfg_wr     = psel && penable && pwrite;
   assign sum_sq     = SQ_W'(sq_x_ff) + SQ_W'(sq_y_ff) + SQ_W'(sq_z_ff);
   assign sqrt_start = state_ff == S_SUM;
   assign accepted   = len_ff >= min_len_ff && len_ff <= max_len_ff;
   assign div_start  = state_ff == S_CHECK && accepted && max_len_ff != min_len_ff;
   assign last_pair  = idx_ff == newer_ff - AW'(1);
   assign start_count = req_word.first ? '0 : count_ff;
   assign next_count = dropped_ff ? count_ff : CNT_W'(newer_ff) + CNT_W'(1);

   // signed differences, stored minus new
   assign dx = {rd_data[3*COORD_W-1], rd_data[3*COORD_W-1], rd_data[3*COORD_W-1 -: COORD_W]}
             - {point_ff[3*COORD_W-1], point_ff[3*COORD_W-1], point_ff[3*COORD_W-1 -: COORD_W]};
   assign dy = {rd_data[2*COORD_W-1], rd_data[2*COORD_W-1], rd_data[2*COORD_W-1 -: COORD_W]}
             - {point_ff[2*COORD_W-1], point_ff[2*COORD_W-1], point_ff[2*COORD_W-1 -: COORD_W]};
   assign dz = {rd_data[COORD_W-1], rd_data[COORD_W-1], rd_data[COORD_W-1:0]}
             - {point_ff[COORD_W-1], point_ff[COORD_W-1], point_ff[COORD_W-1:0]};
   assign ax = dx[LEN_W] ? LEN_W'(-dx) : dx[LEN_W-1:0];
   assign ay = dy[LEN_W] ? LEN_W'(-dy) : dy[LEN_W-1:0];
   assign az = dz[LEN_W] ? LEN_W'(-dz) : dz[LEN_W-1:0];

   always_comb begin
      pair_word             = '0;
      pair_word.kind        = KIND_EDGE;
      pair_word.older_index = IDX_W'(idx_ff);
      pair_word.newer_index = IDX_W'(newer_ff);
      pair_word.edge_length = len_ff;
      pair_word.hue         = (state_ff == S_DIVIDE) ? quot + hue_off_ff : '0;
   end

   always_comb begin
      summary_word             = '0;
      summary_word.kind        = KIND_SUMMARY;
      summary_word.last        = 1'b1;
      summary_word.overflow    = dropped_ff;
      summary_word.point_count = next_count;
      summary_word.shortest    = (next_count < CNT_W'(2)) ? '0 : run_min_ff;
      summary_word.longest     = (next_count < CNT_W'(2)) ? '0 : run_max_ff;
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_MIN_LENGTH: prdata = 32'(min_len_ff);
         CSR_MAX_LENGTH: prdata = 32'(max_len_ff);
         CSR_HUE_OFFSET: prdata = 32'(hue_off_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         min_len_ff <= '0;
         max_len_ff <= '0;
         hue_off_ff <= '0;
         count_ff   <= '0;
         run_min_ff <= '1;
         run_max_ff <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (cfg_wr) begin
            unique case (paddr[3:2])
               CSR_MIN_LENGTH: min_len_ff <= pwdata[LEN_W-1:0];
               CSR_MAX_LENGTH: max_len_ff <= pwdata[LEN_W-1:0];
               CSR_HUE_OFFSET: hue_off_ff <= pwdata[HUE_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  point_ff <= {req_word.coord_x, req_word.coord_y, req_word.coord_z};
                  if (req_word.first) begin
                     count_ff   <= '0;
                     run_min_ff <= '1;
                     run_max_ff <= '0;
                  end
                  idx_ff     <= '0;
                  newer_ff   <= AW'(start_count);
                  dropped_ff <= start_count >= CNT_W'(MAX_POINTS);
                  if (start_count >= CNT_W'(MAX_POINTS) || start_count == '0) begin
                     state_ff <= S_STORE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ:   state_ff <= S_SQUARE;
            S_SQUARE: begin
               sq_x_ff  <= ax * ax;
               sq_y_ff  <= ay * ay;
               sq_z_ff  <= az * az;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (sqrt_done) begin
                  len_ff   <= root;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK, S_DIVIDE: begin
               if (state_ff == S_CHECK) begin
                  if (len_ff < run_min_ff) run_min_ff <= len_ff;
                  if (len_ff > run_max_ff) run_max_ff <= len_ff;
               end
               if ((state_ff == S_CHECK && !div_start) || div_done) begin
                  if (accepted) begin
                     rsp_valid <= 1'b1;
                     rsp_word  <= pair_word;
                  end
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= last_pair ? S_STORE : S_READ;
               end else begin
                  state_ff <= S_DIVIDE;
               end
            end
            S_STORE: begin
               rsp_valid <= 1'b1;
               rsp_word  <= summary_word;
               if (!dropped_ff) begin
                  count_ff <= next_count;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ tb/tb_pairwise_edge_length_filter.sv @@
// Testbench for pairwise_edge_length_filter: random and directed points are
// fed in, each result word is checked against a behavioural predictor.
// Depends on pelf_pkg and the block's RTL only.
`timescale 1ns / 1ps

class edge_scoreboard;
   pelf_pkg::rsp_word_type pending[$];
   logic [23:0] px[64], py[64], pz[64];
   int unsigned count;
   logic [24:0] lo_len, hi_len;
   logic [24:0] min_len, max_len;
   logic [15:0] hue_off;
   int errors;

   function new();
      count = 0; lo_len = '1; hi_len = 0;
      min_len = 0; max_len = 0; hue_off = 0; errors = 0;
   endfunction

   function automatic logic [24:0] root_round(logic [63:0] n);
      logic [63:0] r, b;
      r = 0; b = 64'd1 << 52;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (n > r) r = r + 1;
      return r[24:0];
   endfunction

   function automatic logic [63:0] sq(logic [23:0] a, logic [23:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      if (d < 0) d = -d;
      return d * d;
   endfunction

   function void note_point(pelf_pkg::req_word_type w);
      pelf_pkg::rsp_word_type r;
      logic [24:0] len;
      logic [63:0] frac;
      logic dropped;
      dropped = 0;
      if (w.first) begin
         count = 0; lo_len = '1; hi_len = 0;
      end
      if (count >= 64) begin
         dropped = 1;
      end else begin
         for (int i = 0; i < count; i++) begin
            len = root_round(sq(px[i], w.coord_x) + sq(py[i], w.coord_y)
                             + sq(pz[i], w.coord_z));
            if (len < lo_len) lo_len = len;
            if (len > hi_len) hi_len = len;
            if (len >= min_len && len <= max_len) begin
               r = '0;
               r.kind = pelf_pkg::KIND_EDGE;
               r.older_index = 6'(i);
               r.newer_index = 6'(count);
               r.edge_length = len;
               if (max_len != min_len) begin
                  frac = (64'(len - min_len) << 16) / 64'(max_len - min_len);
                  r.hue = frac[15:0] + hue_off;
               end
               pending.insert(pending.size(), r);
            end
         end
         px[count] = w.coord_x; py[count] = w.coord_y; pz[count] = w.coord_z;
         count++;
      end
      r = '0;
      r.kind = pelf_pkg::KIND_SUMMARY;
      r.shortest = count < 2 ? 25'd0 : lo_len;
      r.longest = count < 2 ? 25'd0 : hi_len;
      r.point_count = 7'(count);
      r.overflow = dropped;
      r.last = 1;
      pending.insert(pending.size(), r);
   endfunction

   function void check_word(pelf_pkg::rsp_word_type got);
      pelf_pkg::rsp_word_type exp_w;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected word %h", got);
         return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
         errors++;
         if (errors <= 10) $display("mismatch: expected %p actual %p", exp_w, got);
      end
   endfunction
endclass

module tb_pairwise_edge_length_filter;
   import pelf_pkg::*;

   logic clock, reset, start, busy, rsp_valid, psel, penable, pwrite, pready;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic [CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;
   edge_scoreboard board;
   bit calm;

   pairwise_edge_length_filter u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb_pairwise_edge_length_filter: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_word(rsp_word);
   end

   task automatic csr_write(logic [1:0] reg_code, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= CSR_AW'(reg_code) << 2; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (reg_code)
         CSR_MIN_LENGTH: board.min_len = value[24:0];
         CSR_MAX_LENGTH: board.max_len = value[24:0];
         default: board.hue_off = value[15:0];
      endcase
   endtask

   task automatic set_window(logic [24:0] lo, logic [24:0] hi, logic [15:0] off);
      csr_write(CSR_MIN_LENGTH, 32'(lo));
      csr_write(CSR_MAX_LENGTH, 32'(hi));
      csr_write(CSR_HUE_OFFSET, 32'(off));
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_point(bit first, logic [23:0] x, logic [23:0] y, logic [23:0] z);
      req_word_type w;
      w.first = first; w.coord_x = x; w.coord_y = y; w.coord_z = z;
      if (!calm) while ($urandom_range(99) < 13) @(posedge clock);
      start <= 1; req_word <= w;
      do @(posedge clock); while (busy);
      board.note_point(w);
      start <= 0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] near_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(2000)) - 1000);
         2: return 24'h800000 | 24'($urandom_range(255));
         default: return 24'h7fff00 | 24'($urandom_range(255));
      endcase
   endfunction

   initial begin
      board = new();
      calm = 0;
      reset = 1; start = 0; req_word = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // equal bounds: hue zero
      set_window(25'd0, 25'd0, 16'hffff);
      send_point(1, 24'h800000, 24'h800000, 24'h800000);
      send_point(0, 24'h800000, 24'h800000, 24'h800000);
      send_point(0, 24'h7fffff, 24'h7fffff, 24'h7fffff);
      send_point(0, 24'h000000, 24'hffffff, 24'h000001);
      drain();
      set_window(25'd0, 25'h1ffffff, 16'h8000);
      send_point(1, 24'h7fffff, 24'h800000, 24'h000000);
      send_point(0, 24'h800000, 24'h7fffff, 24'h000000);
      send_point(0, 24'h800000, 24'h800000, 24'h7fffff);
      send_point(0, 24'h123456, 24'hedcba9, 24'h55aa55);
      drain();
      // min above max: no edges
      set_window(25'h1ffffff, 25'd0, 16'd0);
      send_point(0, 24'h000100, 24'h000200, 24'h000300);
      send_point(1, 24'h000100, 24'h000200, 24'h000300);
      send_point(0, 24'hffff00, 24'h000200, 24'h000300);
      drain();
      // fill the store and overflow it
      set_window(25'h100, 25'h30000, 16'h1234);
      calm = 1;
      for (int i = 0; i < 66; i++)
         send_point(i == 0, near_coord(), near_coord(), near_coord());
      calm = 0;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_window(25'd0, 25'h1ffffff, 16'($urandom));
            1: set_window(25'h10000, 25'h200000, 16'($urandom));
            2: set_window(25'd0, 25'h8000, 16'($urandom));
            default: set_window(25'($urandom_range(20'hfffff)),
                                25'($urandom_range(25'h1ffffff, 25'h100000)),
                                16'($urandom));
         endcase
         for (int i = 0; i < 40; i++)
            send_point(i == 0 || $urandom_range(11) == 0,
                       near_coord(), near_coord(), near_coord());
         drain();
      end

      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_pairwise_edge_length_filter: clean");
      end else begin
         $display("tb_pairwise_edge_length_filter: errors");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/pelf_pkg.sv
rtl/pelf_ram.sv
rtl/pelf_sqrt.sv
rtl/pelf_div.sv
rtl/pairwise_edge_length_filter.sv
tb/tb_pairwise_edge_length_filter.sv
